>>> hdl/b64e_pkg.sv
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [7:0] LOWER_BASE = 8'h61;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] STD_62     = 8'h2B;
  localparam logic [7:0] STD_63     = 8'h2F;
  localparam logic [7:0] URL_62     = 8'h2D;
  localparam logic [7:0] URL_63     = 8'h5F;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_URL_ALPHABET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OMIT_PADDING = 1'd1;

  // one gathered group of up to three bytes
  typedef struct packed {
    logic [23:0] chunk;
    logic [1:0]  nbytes_m1;
    logic        fin;
  } group_t;

  typedef struct packed {
    logic url_alphabet;
    logic omit_padding;
  } cfg_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
    logic [7:0] w;
    logic [7:0] c;
    begin
      w = {2'b00, v};
      if (v < 6'd26) begin
        c = UPPER_BASE + w;
      end else if (v < 6'd52) begin
        c = LOWER_BASE + (w - 8'd26);
      end else if (v < 6'd62) begin
        c = DIGIT_BASE + (w - 8'd52);
      end else if (v == 6'd62) begin
        c = url ? URL_62 : STD_62;
      end else begin
        c = url ? URL_63 : STD_63;
      end
      return c;
    end
  endfunction

endpackage

>>> hdl/b64e_front.sv
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output b64e_pkg::group_t  group_o
);

  logic [1:0]  held_count_q, held_count_d;
  logic [15:0] held_bytes_q, held_bytes_d;
  logic        accept;
  logic        hold;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign hold       = !final_byte_i && (held_count_q < 2'd2);
  assign push_o     = accept && !hold;

  always_comb begin
    group_o.fin = final_byte_i;
    case (held_count_q)
      2'd0: begin
        group_o.chunk     = {data_byte_i, 16'h0000};
        group_o.nbytes_m1 = 2'd0;
      end
      2'd1: begin
        group_o.chunk     = {held_bytes_q[15:8], data_byte_i, 8'h00};
        group_o.nbytes_m1 = 2'd1;
      end
      default: begin
        group_o.chunk     = {held_bytes_q, data_byte_i};
        group_o.nbytes_m1 = 2'd2;
      end
    endcase
  end

  always_comb begin
    held_count_d = held_count_q;
    held_bytes_d = held_bytes_q;
    if (accept) begin
      if (hold) begin
        held_count_d = held_count_q + 2'd1;
        if (held_count_q == 2'd0) begin
          held_bytes_d = {data_byte_i, 8'h00};
        end else begin
          held_bytes_d = {held_bytes_q[15:8], data_byte_i};
        end
      end else begin
        held_count_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 2'd0;
    end else begin
      held_count_q <= held_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_bytes_q <= held_bytes_d;
  end

endmodule

>>> hdl/b64e_fifo.sv
module b64e_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  b64e_pkg::group_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output b64e_pkg::group_t  pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::group_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/b64e_back.sv
module b64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64e_pkg::cfg_t    cfg_i,
  input  logic              grp_valid_i,
  output logic              grp_pop_o,
  input  b64e_pkg::group_t  grp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              run_end_o,
  output logic              message_end_o
);

  logic              cur_valid_q, cur_valid_d;
  b64e_pkg::group_t  cur_q, cur_d;
  logic [1:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              run_end_q, run_end_d;
  logic              msg_end_q, msg_end_d;

  logic              out_adv;
  logic              emit;
  logic [1:0]        last_real;
  logic [1:0]        last_idx;
  logic              is_last;
  logic [5:0]        sextet;
  logic [7:0]        char_now;

  assign out_adv   = !out_valid_q || out_ready_i;
  assign emit      = cur_valid_q && out_adv;
  assign last_real = cur_q.nbytes_m1 + 2'd1;
  assign last_idx  = cfg_i.omit_padding ? last_real : 2'd3;
  assign is_last   = (idx_q == last_idx);
  assign grp_pop_o = grp_valid_i && (!cur_valid_q || (emit && is_last));

  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.chunk[23:18];
      2'd1:    sextet = cur_q.chunk[17:12];
      2'd2:    sextet = cur_q.chunk[11:6];
      default: sextet = cur_q.chunk[5:0];
    endcase
    char_now = (idx_q <= last_real) ? b64e_pkg::sextet_char(sextet, cfg_i.url_alphabet)
                                    : b64e_pkg::PAD_CHAR;
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    run_end_d   = run_end_q;
    msg_end_d   = msg_end_q;
    if (out_adv) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_char_d = char_now;
      run_end_d  = is_last;
      msg_end_d  = is_last && cur_q.fin;
      idx_d      = idx_q + 2'd1;
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (grp_pop_o) begin
      cur_valid_d = 1'b1;
      cur_d       = grp_i;
      idx_d       = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
    run_end_q  <= run_end_d;
    msg_end_q  <= msg_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign run_end_o     = run_end_q;
  assign message_end_o = msg_end_q;

endmodule

>>> hdl/base64_stream_encoder.sv
// channel | direction | tdata            | tlast       | tuser
// s_axis  | in        | [7:0] data_byte  | final_byte  | -
// m_axis  | out       | [7:0] out_char   | run_end     | message_end
// cfg     | in        | cfg_data_i: register value, cfg_idx_i: register index
//
// bytes are taken one per cycle while the group queue has room
// characters leave one per cycle from the output register while m_axis_tready is high:
// 4 characters per 3-byte group, 2 to 4 characters for a short final group
// reset clears held byte count, queue, output valid and both config registers
// m_axis_tready low holds the output; the queue of FIFO_DEPTH groups keeps s_axis open
module base64_stream_encoder #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // data_byte
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // out_char
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser,  // message_end
  input  logic                                cfg_we_i,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [b64e_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  b64e_pkg::cfg_t    cfg_q, cfg_d;
  b64e_pkg::group_t  push_grp;
  b64e_pkg::group_t  pop_grp;
  logic              push;
  logic              push_ready;
  logic              pop_valid;
  logic              pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        b64e_pkg::CFG_URL_ALPHABET: cfg_d.url_alphabet = cfg_data_i[0];
        b64e_pkg::CFG_OMIT_PADDING: cfg_d.omit_padding = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .push_o       (push),
    .push_ready_i (push_ready),
    .group_o      (push_grp)
  );

  b64e_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_grp),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_grp)
  );

  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .grp_valid_i   (pop_valid),
    .grp_pop_o     (pop),
    .grp_i         (pop_grp),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_char_o    (m_axis_tdata),
    .run_end_o     (m_axis_tlast),
    .message_end_o (m_axis_tuser)
  );

endmodule

>>> hdl/b64e_checker.sv
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // output valid is low when reset is released
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid at reset release");

  // a stalled item keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled item changed");

  // message end only on the last character of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("message end without run end");

  // a pad closing a run only happens at message end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && (m_axis_tdata == b64e_pkg::PAD_CHAR) |-> m_axis_tuser)
    else $error("pad outside final group");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
